>>> hw/rtl/led_pkg.sv
// Line editor package: request kinds, key codes and default sizes.
// No dependencies; imported by the interfaces, the top level and the checker.
package led_pkg;

    localparam int LINE_CHARS_DEF    = 128;
    localparam int HISTORY_DEPTH_DEF = 16;

    localparam int KIND_W  = 4;
    localparam int CHAR_W  = 8;
    localparam int INDEX_W = 7;

    localparam logic [KIND_W-1:0] KIND_KEY       = 4'd0;
    localparam logic [KIND_W-1:0] KIND_LEFT      = 4'd1;
    localparam logic [KIND_W-1:0] KIND_RIGHT     = 4'd2;
    localparam logic [KIND_W-1:0] KIND_UP        = 4'd3;
    localparam logic [KIND_W-1:0] KIND_DOWN      = 4'd4;
    localparam logic [KIND_W-1:0] KIND_READ      = 4'd5;
    localparam logic [KIND_W-1:0] KIND_RELEASE   = 4'd6;
    localparam logic [KIND_W-1:0] KIND_CANCEL    = 4'd7;
    localparam logic [KIND_W-1:0] KIND_CLR_CANCEL = 4'd8;

    localparam logic [CHAR_W-1:0] KEY_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] KEY_NL    = 8'd10;
    localparam logic [CHAR_W-1:0] PRINT_LO  = 8'd32;
    localparam logic [CHAR_W-1:0] PRINT_HI  = 8'd126;

endpackage

>>> hw/rtl/led_if.sv
// Request and result channel interfaces of the line editor.
// Depends on led_pkg for field widths.
interface led_cmd_if import led_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [CHAR_W-1:0]   key_code;
    logic [INDEX_W-1:0]  read_index;

    modport source (output valid, kind, key_code, read_index, input ready);
    modport sink   (input valid, kind, key_code, read_index, output ready);
endinterface

interface led_res_if import led_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CHAR_W-1:0]   char_out;
    logic [INDEX_W-1:0]  line_length;
    logic [INDEX_W-1:0]  cursor_pos;
    logic                line_waiting;
    logic                cancel_flag;
    logic                line_changed;

    modport source (output valid, char_out, line_length, cursor_pos, line_waiting,
                    cancel_flag, line_changed, input ready);
    modport sink   (input valid, char_out, line_length, cursor_pos, line_waiting,
                    cancel_flag, line_changed, output ready);
endinterface

>>> hw/rtl/line_editor_with_history_unit.sv
// Line editor with history ring: top level, sequencer and both memories.
// Depends on led_pkg and the channel interfaces in led_if.sv.
//
// One request is taken at a time; cmd.ready is high only while the sequencer
// is idle. Cursor moves, cancel, release and flag requests go straight to
// the final state; a character read passes through a read state first.
// Insert and backspace move the tail of the line one character per read
// and write-back pair of states through the line memory, which has one
// read port and one write port. Enter copies the line into the history
// memory one character at a time. Up may first compare the line against
// the browsed entry and then loads the entry, so up is the slowest
// request; down loads the next newer entry or clears the line. Each
// result waits in an output register; the sequencer stalls in its final
// state only while a previous result is still unread.
module line_editor_with_history_unit
    import led_pkg::*;
#(
    parameter int LINE_CHARS    = LINE_CHARS_DEF,
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    led_cmd_if.sink     cmd,
    led_res_if.source   res
);

    localparam int LW = $clog2(LINE_CHARS);
    localparam int SW = $clog2(HISTORY_DEPTH);
    localparam int EW = $clog2(HISTORY_DEPTH + 1);
    localparam int HA = $clog2(HISTORY_DEPTH * LINE_CHARS);
    localparam int CW = ((LW > INDEX_W) ? LW : INDEX_W) + 1;
    localparam logic [LW-1:0] LEN_MAX = LW'(LINE_CHARS - 1);
    localparam logic [SW-1:0] SLOT_LAST = SW'(HISTORY_DEPTH - 1);
    localparam logic [EW-1:0] ENTRIES_MAX = EW'(HISTORY_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE, S_RD_CHAR,
        S_INS_RD, S_INS_WR, S_DEL_RD, S_DEL_WR,
        S_PUSH_BASE, S_PUSH_RD, S_PUSH_WR,
        S_CMP_BASE, S_CMP_LEN, S_CMP_RD, S_CMP_CHK,
        S_UP_STEP, S_LOAD_SEL, S_LOAD_BASE, S_LOAD_RD, S_LOAD_WR,
        S_DONE
    } state_t;

    state_t              state_reg;
    logic [CHAR_W-1:0]   key_reg;
    logic [INDEX_W-1:0]  idx_reg;
    logic [LW-1:0]       ptr_reg;
    logic [LW-1:0]       len_reg;
    logic [LW-1:0]       cursor_reg;
    logic                ready_reg;
    logic                cancel_reg;
    logic [EW-1:0]       entries_reg;
    logic [SW-1:0]       newest_reg;
    logic [EW-1:0]       browse_reg;
    logic [SW-1:0]       slot_reg;
    logic [HA-1:0]       base_reg;
    logic [CHAR_W-1:0]   ch_reg;
    logic                changed_reg;

    logic                out_valid_reg;
    logic [CHAR_W-1:0]   out_char_reg;
    logic [INDEX_W-1:0]  out_len_reg;
    logic [INDEX_W-1:0]  out_cursor_reg;
    logic                out_ready_reg;
    logic                out_cancel_reg;
    logic                out_changed_reg;

    // memories
    logic [CHAR_W-1:0] line_mem [LINE_CHARS];
    logic [CHAR_W-1:0] hist_mem [HISTORY_DEPTH * LINE_CHARS];
    logic [LW-1:0]     hlen_mem [HISTORY_DEPTH];
    logic [CHAR_W-1:0] line_rdata;
    logic [CHAR_W-1:0] hist_rdata;
    logic [LW-1:0]     hlen_rdata;

    logic              line_we;
    logic [LW-1:0]     line_raddr;
    logic [LW-1:0]     line_waddr;
    logic [CHAR_W-1:0] line_wdata;
    logic              hist_we;
    logic              hlen_we;
    logic [HA-1:0]     hist_addr;

    logic              accept;
    logic              out_free;
    logic [SW-1:0]     slot_next;
    logic [SW-1:0]     slot_browse;
    logic [SW:0]       back_sum;
    logic [SW-1:0]     back;
    logic              printable;

    assign accept    = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || res.ready;
    assign printable = (cmd.key_code >= PRINT_LO) && (cmd.key_code <= PRINT_HI);

    // ring slot arithmetic: next slot, and slot of the browsed entry
    assign slot_next   = (newest_reg == SLOT_LAST) ? '0 : SW'(newest_reg + 1'b1);
    assign back        = SW'(browse_reg - 1'b1);
    assign back_sum    = (SW+1)'(newest_reg) + (SW+1)'(HISTORY_DEPTH) - (SW+1)'(back);
    assign slot_browse = (back_sum >= (SW+1)'(HISTORY_DEPTH))
                       ? SW'(back_sum - (SW+1)'(HISTORY_DEPTH)) : SW'(back_sum);

    assign hist_addr = base_reg + HA'(ptr_reg);

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:   line_raddr = LW'(cmd.read_index);
            S_INS_RD: line_raddr = LW'(ptr_reg - 1'b1);
            S_DEL_RD: line_raddr = LW'(ptr_reg + 1'b1);
            default:  line_raddr = ptr_reg;
        endcase
    end

    always_comb
    begin
        line_we    = 1'b0;
        line_waddr = ptr_reg;
        line_wdata = line_rdata;
        hist_we    = (state_reg == S_PUSH_WR);
        hlen_we    = (state_reg == S_PUSH_RD) && (ptr_reg == len_reg);
        unique case (state_reg)
            S_INS_RD:
            begin
                if (ptr_reg == cursor_reg)
                begin
                    line_we    = 1'b1;
                    line_waddr = cursor_reg;
                    line_wdata = key_reg;
                end
            end
            S_INS_WR, S_DEL_WR:
                line_we = 1'b1;
            S_LOAD_WR:
            begin
                line_we    = 1'b1;
                line_wdata = hist_rdata;
            end
            default:
                line_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (line_we)
            line_mem[line_waddr] <= line_wdata;
        line_rdata <= line_mem[line_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[hist_addr] <= line_rdata;
        hist_rdata <= hist_mem[hist_addr];
    end

    always_ff @(posedge clk)
    begin
        if (hlen_we)
            hlen_mem[slot_reg] <= len_reg;
        hlen_rdata <= hlen_mem[slot_reg];
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            key_reg     <= '0;
            idx_reg     <= '0;
            ptr_reg     <= '0;
            len_reg     <= '0;
            cursor_reg  <= '0;
            ready_reg   <= 1'b0;
            cancel_reg  <= 1'b0;
            entries_reg <= '0;
            newest_reg  <= SLOT_LAST;
            browse_reg  <= '0;
            slot_reg    <= '0;
            base_reg    <= '0;
            ch_reg      <= '0;
            changed_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        ch_reg      <= '0;
                        changed_reg <= 1'b0;
                        key_reg     <= cmd.key_code;
                        idx_reg     <= cmd.read_index;
                        state_reg   <= S_DONE;
                        // editing is frozen while a finished line waits
                        if (!(cmd.kind <= KIND_DOWN && ready_reg))
                        begin
                            unique case (cmd.kind)
                                KIND_KEY:
                                begin
                                    priority if (cmd.key_code == KEY_NL)
                                    begin
                                        if (len_reg != '0)
                                        begin
                                            slot_reg  <= slot_next;
                                            state_reg <= S_PUSH_BASE;
                                        end
                                        else
                                            ready_reg <= 1'b1;
                                    end
                                    else if (cmd.key_code == KEY_BS)
                                    begin
                                        if (cursor_reg != '0)
                                        begin
                                            ptr_reg   <= LW'(cursor_reg - 1'b1);
                                            state_reg <= S_DEL_RD;
                                        end
                                    end
                                    else if (printable)
                                    begin
                                        if (len_reg < LEN_MAX)
                                        begin
                                            ptr_reg   <= len_reg;
                                            state_reg <= S_INS_RD;
                                        end
                                    end
                                    else
                                    begin
                                        // tab and other non-printable bytes: no change
                                    end
                                end
                                KIND_LEFT:
                                    if (cursor_reg != '0)
                                        cursor_reg <= LW'(cursor_reg - 1'b1);
                                KIND_RIGHT:
                                    if (cursor_reg < len_reg)
                                        cursor_reg <= LW'(cursor_reg + 1'b1);
                                KIND_UP:
                                begin
                                    if (entries_reg != '0)
                                    begin
                                        if (browse_reg == '0)
                                            state_reg <= S_UP_STEP;
                                        else
                                        begin
                                            slot_reg  <= slot_browse;
                                            state_reg <= S_CMP_BASE;
                                        end
                                    end
                                end
                                KIND_DOWN:
                                begin
                                    if (entries_reg != '0)
                                    begin
                                        if (browse_reg <= EW'(1))
                                        begin
                                            len_reg     <= '0;
                                            cursor_reg  <= '0;
                                            browse_reg  <= '0;
                                            changed_reg <= 1'b1;
                                        end
                                        else
                                        begin
                                            browse_reg <= EW'(browse_reg - 1'b1);
                                            state_reg  <= S_LOAD_SEL;
                                        end
                                    end
                                end
                                KIND_READ:
                                    state_reg <= S_RD_CHAR;
                                KIND_RELEASE:
                                begin
                                    if (ready_reg)
                                    begin
                                        len_reg    <= '0;
                                        cursor_reg <= '0;
                                        ready_reg  <= 1'b0;
                                        browse_reg <= '0;
                                    end
                                end
                                KIND_CANCEL:
                                begin
                                    cancel_reg <= 1'b1;
                                    len_reg    <= '0;
                                    cursor_reg <= '0;
                                    ready_reg  <= 1'b1;
                                end
                                KIND_CLR_CANCEL:
                                    cancel_reg <= 1'b0;
                                default:
                                    state_reg <= S_DONE;
                            endcase
                        end
                    end
                end
                S_RD_CHAR:
                begin
                    if ((CW'(idx_reg) < CW'(len_reg)) && (CW'(idx_reg) < CW'(LINE_CHARS)))
                        ch_reg <= line_rdata;
                    state_reg <= S_DONE;
                end
                // insert: shift tail right, then drop the key in at the cursor
                S_INS_RD:
                begin
                    if (ptr_reg == cursor_reg)
                    begin
                        len_reg     <= LW'(len_reg + 1'b1);
                        cursor_reg  <= LW'(cursor_reg + 1'b1);
                        changed_reg <= 1'b1;
                        state_reg   <= S_DONE;
                    end
                    else
                        state_reg <= S_INS_WR;
                end
                S_INS_WR:
                begin
                    ptr_reg   <= LW'(ptr_reg - 1'b1);
                    state_reg <= S_INS_RD;
                end
                // backspace: shift tail left over the deleted character
                S_DEL_RD:
                begin
                    if ((LW+1)'(ptr_reg) + 1'b1 >= (LW+1)'(len_reg))
                    begin
                        len_reg     <= LW'(len_reg - 1'b1);
                        cursor_reg  <= LW'(cursor_reg - 1'b1);
                        changed_reg <= 1'b1;
                        state_reg   <= S_DONE;
                    end
                    else
                        state_reg <= S_DEL_WR;
                end
                S_DEL_WR:
                begin
                    ptr_reg   <= LW'(ptr_reg + 1'b1);
                    state_reg <= S_DEL_RD;
                end
                // enter: copy line into the next ring slot
                S_PUSH_BASE:
                begin
                    base_reg  <= HA'(slot_reg) * HA'(LINE_CHARS);
                    ptr_reg   <= '0;
                    state_reg <= S_PUSH_RD;
                end
                S_PUSH_RD:
                begin
                    if (ptr_reg == len_reg)
                    begin
                        newest_reg <= slot_reg;
                        if (entries_reg < ENTRIES_MAX)
                            entries_reg <= EW'(entries_reg + 1'b1);
                        browse_reg <= '0;
                        ready_reg  <= 1'b1;
                        state_reg  <= S_DONE;
                    end
                    else
                        state_reg <= S_PUSH_WR;
                end
                S_PUSH_WR:
                begin
                    ptr_reg   <= LW'(ptr_reg + 1'b1);
                    state_reg <= S_PUSH_RD;
                end
                // up: check the line still matches the browsed entry
                S_CMP_BASE:
                begin
                    base_reg  <= HA'(slot_reg) * HA'(LINE_CHARS);
                    ptr_reg   <= '0;
                    state_reg <= S_CMP_LEN;
                end
                S_CMP_LEN:
                begin
                    if (hlen_rdata != len_reg)
                    begin
                        browse_reg <= '0;
                        state_reg  <= S_UP_STEP;
                    end
                    else
                        state_reg <= S_CMP_RD;
                end
                S_CMP_RD:
                begin
                    if (ptr_reg == len_reg)
                        state_reg <= S_UP_STEP;
                    else
                        state_reg <= S_CMP_CHK;
                end
                S_CMP_CHK:
                begin
                    if (line_rdata != hist_rdata)
                    begin
                        browse_reg <= '0;
                        state_reg  <= S_UP_STEP;
                    end
                    else
                    begin
                        ptr_reg   <= LW'(ptr_reg + 1'b1);
                        state_reg <= S_CMP_RD;
                    end
                end
                S_UP_STEP:
                begin
                    priority if (browse_reg == '0)
                    begin
                        browse_reg <= EW'(1);
                        state_reg  <= S_LOAD_SEL;
                    end
                    else if (browse_reg >= entries_reg)
                        state_reg <= S_DONE;
                    else
                    begin
                        browse_reg <= EW'(browse_reg + 1'b1);
                        state_reg  <= S_LOAD_SEL;
                    end
                end
                // load the browsed entry into the line
                S_LOAD_SEL:
                begin
                    slot_reg  <= slot_browse;
                    state_reg <= S_LOAD_BASE;
                end
                S_LOAD_BASE:
                begin
                    base_reg  <= HA'(slot_reg) * HA'(LINE_CHARS);
                    ptr_reg   <= '0;
                    state_reg <= S_LOAD_RD;
                end
                S_LOAD_RD:
                begin
                    if (ptr_reg == hlen_rdata)
                    begin
                        len_reg     <= hlen_rdata;
                        cursor_reg  <= hlen_rdata;
                        changed_reg <= 1'b1;
                        state_reg   <= S_DONE;
                    end
                    else
                        state_reg <= S_LOAD_WR;
                end
                S_LOAD_WR:
                begin
                    ptr_reg   <= LW'(ptr_reg + 1'b1);
                    state_reg <= S_LOAD_RD;
                end
                S_DONE:
                    if (out_free)
                        state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            out_char_reg    <= '0;
            out_len_reg     <= '0;
            out_cursor_reg  <= '0;
            out_ready_reg   <= 1'b0;
            out_cancel_reg  <= 1'b0;
            out_changed_reg <= 1'b0;
        end
        else if (state_reg == S_DONE && out_free)
        begin
            out_valid_reg   <= 1'b1;
            out_char_reg    <= ch_reg;
            out_len_reg     <= INDEX_W'(len_reg);
            out_cursor_reg  <= INDEX_W'(cursor_reg);
            out_ready_reg   <= ready_reg;
            out_cancel_reg  <= cancel_reg;
            out_changed_reg <= changed_reg;
        end
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    assign res.valid        = out_valid_reg;
    assign res.char_out     = out_char_reg;
    assign res.line_length  = out_len_reg;
    assign res.cursor_pos   = out_cursor_reg;
    assign res.line_waiting = out_ready_reg;
    assign res.cancel_flag  = out_cancel_reg;
    assign res.line_changed = out_changed_reg;

endmodule

>>> hw/rtl/led_checker.sv
// Port-level checker for the line editor, bound to the top level.
// Depends on led_pkg and line_editor_with_history_unit.
module led_checker
    import led_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               cmd_valid,
    input logic               cmd_ready,
    input logic               res_valid,
    input logic               res_ready,
    input logic [CHAR_W-1:0]  char_out,
    input logic [INDEX_W-1:0] line_length,
    input logic [INDEX_W-1:0] cursor_pos,
    input logic               line_changed
);

    // one request in flight: an accepted request drops ready
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> !cmd_ready)
        else $error("request taken while busy");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> res_valid && $stable(char_out))
        else $error("result dropped before taken");

    a_cursor_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> cursor_pos <= line_length)
        else $error("cursor past end of line");

    // only printable characters are ever stored, and reads change nothing
    a_char_printable: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && char_out != '0) |->
            (char_out >= PRINT_LO && char_out <= PRINT_HI && !line_changed))
        else $error("bad character read back");

endmodule

bind line_editor_with_history_unit led_checker u_led_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd.valid),
    .cmd_ready    (cmd.ready),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .char_out     (res.char_out),
    .line_length  (res.line_length),
    .cursor_pos   (res.cursor_pos),
    .line_changed (res.line_changed)
);

>>> tb/tb_line_editor_with_history_unit_chk.sv
// Checker for the line editor: models line, cursor, flags and history ring.
// Depends on led_pkg and the channel interfaces; watches both channels.
module tb_line_editor_with_history_unit_chk
    import led_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    led_cmd_if      cmd,
    led_res_if      res,
    output int      fail_count,
    output int      pending
);

    localparam int LC = LINE_CHARS_DEF;
    localparam int HD = HISTORY_DEPTH_DEF;

    typedef struct packed {
        logic [CHAR_W-1:0]  ch;
        logic [INDEX_W-1:0] len;
        logic [INDEX_W-1:0] cur;
        logic               rdy;
        logic               canc;
        logic               chg;
    } editor_view_t;

    logic [CHAR_W-1:0] text [LC];
    logic [CHAR_W-1:0] hist_text [HD][LC];
    int hist_len [HD];
    int len, cur, rdy, canc, entries, newest, depth;
    editor_view_t expected_views [$];

    function automatic int slot_at(int d);
        return (newest + HD - ((d - 1) % HD)) % HD;
    endfunction

    function automatic void recall(int d);
        int s;
        s = slot_at(d);
        len = hist_len[s];
        for (int i = 0; i < len; i++) text[i] = hist_text[s][i];
        cur = len;
    endfunction

    function automatic bit matches_entry(int d);
        int s;
        s = slot_at(d);
        if (hist_len[s] != len) return 0;
        for (int i = 0; i < len; i++)
            if (text[i] != hist_text[s][i]) return 0;
        return 1;
    endfunction

    function automatic editor_view_t edit_line(logic [KIND_W-1:0] k,
                                              logic [CHAR_W-1:0] key,
                                              logic [INDEX_W-1:0] idx);
        editor_view_t v;
        int s;
        v = '0;
        if (k <= KIND_DOWN && rdy) k = 4'hF;
        case (k)
            KIND_KEY:
                if (key == KEY_NL) begin
                    if (len > 0) begin
                        s = (newest + 1) % HD;
                        for (int i = 0; i < len; i++) hist_text[s][i] = text[i];
                        hist_len[s] = len;
                        newest = s;
                        if (entries < HD) entries++;
                        depth = 0;
                    end
                    rdy = 1;
                end else if (key == KEY_BS) begin
                    if (cur > 0) begin
                        for (int i = cur - 1; i + 1 < len; i++) text[i] = text[i+1];
                        len--; cur--; v.chg = 1;
                    end
                end else if (key >= PRINT_LO && key <= PRINT_HI && len < LC - 1) begin
                    for (int i = len; i > cur; i--) text[i] = text[i-1];
                    text[cur] = key;
                    len++; cur++; v.chg = 1;
                end
            KIND_LEFT:  if (cur > 0) cur--;
            KIND_RIGHT: if (cur < len) cur++;
            KIND_UP:
                if (entries > 0) begin
                    if (depth > 0 && !matches_entry(depth)) depth = 0;
                    if (depth == 0) begin
                        depth = 1; recall(depth); v.chg = 1;
                    end else if (depth < entries) begin
                        depth++; recall(depth); v.chg = 1;
                    end
                end
            KIND_DOWN:
                if (entries > 0) begin
                    if (depth <= 1) begin
                        len = 0; cur = 0; depth = 0;
                    end else begin
                        depth--; recall(depth);
                    end
                    v.chg = 1;
                end
            KIND_READ: if (idx < len) v.ch = text[idx];
            KIND_RELEASE:
                if (rdy) begin
                    len = 0; cur = 0; rdy = 0; depth = 0;
                end
            KIND_CANCEL: begin
                canc = 1; len = 0; cur = 0; rdy = 1;
            end
            KIND_CLR_CANCEL: canc = 0;
            default: ;
        endcase
        v.len = INDEX_W'(len);
        v.cur = INDEX_W'(cur);
        v.rdy = 1'(rdy);
        v.canc = 1'(canc);
        return v;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    assign pending = expected_views.size();

    always @(posedge clk or negedge rst_n) begin
        editor_view_t e;
        if (!rst_n) begin
            len = 0; cur = 0; rdy = 0; canc = 0;
            entries = 0; newest = HD - 1; depth = 0;
            fail_count = 0;
            expected_views.delete();
        end else begin
            if (cmd.valid && cmd.ready)
                expected_views.push_back(edit_line(cmd.kind, cmd.key_code, cmd.read_index));
            if (res.valid && res.ready) begin
                if (expected_views.size() == 0) begin
                    report("unexpected result", 1, 0);
                end else begin
                    e = expected_views.pop_front();
                    if (res.char_out != e.ch) report("char_out", res.char_out, e.ch);
                    if (res.line_length != e.len) report("line_length", res.line_length, e.len);
                    if (res.cursor_pos != e.cur) report("cursor_pos", res.cursor_pos, e.cur);
                    if (res.line_waiting != e.rdy)
                        report("line_waiting", res.line_waiting, e.rdy);
                    if (res.cancel_flag != e.canc) report("cancel_flag", res.cancel_flag, e.canc);
                    if (res.line_changed != e.chg)
                        report("line_changed", res.line_changed, e.chg);
                end
            end
        end
    end

endmodule

>>> tb/tb_line_editor_with_history_unit.sv
// Testbench top for the line editor: clock, reset, request stimulus, verdict.
// Depends on led_pkg, the channel interfaces, the block and the checker.
module tb_line_editor_with_history_unit
    import led_pkg::*;
();

    localparam int RANDOM_REQS = 1590;
    localparam int STALL_LIMIT = 20000; // idle cycles; far above the slowest request (up)

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   quiet_cycles = 0;
    int   line_est;      // rough line length, used to bias the stimulus
    bit   waiting;       // a finished line is believed to be waiting

    led_cmd_if cmd ();
    led_res_if res ();

    line_editor_with_history_unit dut (.clk(clk), .rst_n(rst_n), .cmd(cmd), .res(res));

    tb_line_editor_with_history_unit_chk chk (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .res(res),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b0; #6;
        clk = 1'b1; #6;
    end

    // Receiver: alternates between free-running stretches and random stalls.
    int stall_mode = 0;
    always @(negedge clk)
    begin
        if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: res.ready <= 1'b1;
            1: res.ready <= ($urandom_range(0, 3) != 0);
            default: res.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Watchdog: any accepted request or result clears the count.
    always @(posedge clk)
    begin
        if ((cmd.valid && cmd.ready) || (res.valid && res.ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Drive one request and hold it until accepted; valid stays high
    // when the next request follows without a gap.
    task automatic send(logic [KIND_W-1:0] k, logic [CHAR_W-1:0] key,
                        logic [INDEX_W-1:0] idx);
        cmd.valid      <= 1'b1;
        cmd.kind       <= k;
        cmd.key_code   <= key;
        cmd.read_index <= idx;
        do @(posedge clk); while (!(cmd.valid && cmd.ready));
        @(negedge clk);
        if (k == KIND_KEY && key == KEY_NL) waiting = 1;
        if (k == KIND_CANCEL) begin waiting = 1; line_est = 0; end
        if (k == KIND_RELEASE) begin waiting = 0; line_est = 0; end
        if (k == KIND_KEY && key >= PRINT_LO && key <= PRINT_HI && !waiting
            && line_est < 127)
            line_est++;
    endtask

    task automatic gap(int n);
        cmd.valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic type_text(int n);
        for (int i = 0; i < n; i++)
            send(KIND_KEY, 8'($urandom_range(PRINT_LO, PRINT_HI)), 7'($urandom));
    endtask

    // Mostly well-formed sessions: type, browse, edit, enter, read, release.
    task automatic random_request();
        int r;
        r = $urandom_range(0, 99);
        if (waiting && r < 45)
        begin
            if (r < 30) send(KIND_READ, 8'($urandom), 7'($urandom_range(0, line_est + 2)));
            else send(KIND_RELEASE, 8'($urandom), 7'($urandom));
        end
        else if (r < 50) send(KIND_KEY, 8'($urandom_range(PRINT_LO, PRINT_HI)), 7'($urandom));
        else if (r < 56) send(KIND_KEY, KEY_BS, 7'($urandom));
        else if (r < 61) send(KIND_KEY, KEY_NL, 7'($urandom));
        else if (r < 64) send(KIND_KEY, 8'($urandom), 7'($urandom));
        else if (r < 70) send(KIND_LEFT, 8'($urandom), 7'($urandom));
        else if (r < 75) send(KIND_RIGHT, 8'($urandom), 7'($urandom));
        else if (r < 83) send(KIND_UP, 8'($urandom), 7'($urandom));
        else if (r < 88) send(KIND_DOWN, 8'($urandom), 7'($urandom));
        else if (r < 94) send(KIND_READ, 8'($urandom), 7'($urandom));
        else if (r < 96) send(KIND_RELEASE, 8'($urandom), 7'($urandom));
        else if (r < 97) send(KIND_CANCEL, 8'($urandom), 7'($urandom));
        else if (r < 98) send(KIND_CLR_CANCEL, 8'($urandom), 7'($urandom));
        else send(4'($urandom_range(9, 15)), 8'($urandom), 7'($urandom));
    endtask

    initial
    begin
        int burst;
        rst_n          = 1'b0;
        cmd.valid      = 1'b0;
        cmd.kind       = KIND_KEY;
        cmd.key_code   = '0;
        cmd.read_index = '0;
        line_est       = 0;
        waiting        = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty history up/down, edge keys, full line, browsing.
        send(KIND_UP, 8'hFF, 7'h7F);
        send(KIND_DOWN, 8'h00, 7'h00);
        send(KIND_KEY, KEY_BS, 7'h00);         // backspace at cursor 0
        send(KIND_KEY, 8'd9, 7'h00);           // tab ignored
        send(KIND_KEY, 8'hFF, 7'h00);          // non-printable
        send(KIND_KEY, PRINT_LO, 7'h00);
        send(KIND_KEY, PRINT_HI, 7'h00);
        send(KIND_KEY, 8'd127, 7'h00);
        send(KIND_LEFT, 8'h00, 7'h00);
        send(KIND_KEY, 8'h41, 7'h00);          // mid-line insert
        send(KIND_RIGHT, 8'h00, 7'h00);
        send(KIND_RIGHT, 8'h00, 7'h00);        // right at end
        send(KIND_RELEASE, 8'h00, 7'h00);      // release with nothing waiting
        send(KIND_KEY, KEY_NL, 7'h00);
        send(KIND_KEY, 8'h42, 7'h00);          // edit while a line waits
        send(KIND_READ, 8'h00, 7'h00);
        send(KIND_READ, 8'h00, 7'h7F);         // beyond length
        send(KIND_RELEASE, 8'h00, 7'h00);
        send(KIND_KEY, KEY_NL, 7'h00);         // empty enter
        send(KIND_RELEASE, 8'h00, 7'h00);
        type_text(130);                        // fills the line, extras ignored
        send(KIND_READ, 8'h00, 7'd126);
        send(KIND_KEY, KEY_NL, 7'h00);
        send(KIND_RELEASE, 8'h00, 7'h00);
        send(KIND_UP, 8'h00, 7'h00);
        send(KIND_UP, 8'h00, 7'h00);           // oldest entry
        send(KIND_DOWN, 8'h00, 7'h00);
        send(KIND_CANCEL, 8'h00, 7'h00);
        send(KIND_CLR_CANCEL, 8'h00, 7'h00);
        send(KIND_RELEASE, 8'h00, 7'h00);
        send(4'd15, 8'h00, 7'h00);

        // Hold off until every result is back.
        gap(1);
        while (pending != 0) @(negedge clk);
        line_est = 0;

        for (int n = 0; n < RANDOM_REQS; )
        begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && n < RANDOM_REQS; b++, n++) random_request();
            if ($urandom_range(0, 2) != 0) gap($urandom_range(1, 30));
        end
        gap(1);

        while (pending != 0) @(negedge clk);
        repeat (600) @(negedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
